### hw/rtl/spq_pkg.sv
// spq_pkg: types, codes and sizes shared by the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue.
package spq_pkg;

  localparam int KeyW     = 32;
  localparam int TagW     = 9;
  localparam int PosW     = 6;
  localparam int CountW   = 6;
  localparam int StatusW  = 2;
  localparam int DepthDef = 32;

  localparam logic FuncInsert = 1'b0;
  localparam logic FuncDelete = 1'b1;

  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusFull     = 2'd1;
  localparam logic [StatusW-1:0] StatusBadPos   = 2'd2;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic            func;
    logic [KeyW-1:0] entry_key;
    logic [TagW-1:0] entry_tag;
    logic [PosW-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  entry_count;
    logic [KeyW-1:0]    removed_key;
    logic [TagW-1:0]    removed_tag;
    logic [KeyW-1:0]    head_key;
    logic [TagW-1:0]    head_tag;
    logic               empty_res;
  } out_item_t;

  // Broadcast to every cell; ins/del already qualified by accept and checks.
  typedef struct packed {
    logic            ins;
    logic            del;
    entry_t          ent;
    logic [PosW-1:0] position;
  } cmd_t;

endpackage

### hw/rtl/spq_cell.sv
// spq_cell: one slot of the shift-register queue (entry plus valid flag).
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cmd_t   cmd_i,
  input  entry_t left_ent_i,
  input  logic   left_valid_i,
  input  logic   left_lt_i,
  input  entry_t right_ent_i,
  input  logic   right_valid_i,
  output entry_t ent_o,
  output logic   valid_o,
  output logic   lt_o,
  output entry_t nxt_o,
  output entry_t sel_o
);

  localparam logic [PosW-1:0] MyIdx = PosW'(INDEX);

  entry_t ent_q, ent_d;
  logic   valid_q, valid_d;
  logic   lt;
  logic   at_or_after;

  assign lt          = valid_q && (ent_q.key < cmd_i.ent.key);
  assign at_or_after = (MyIdx >= cmd_i.position);

  always_comb begin
    ent_d   = ent_q;
    valid_d = valid_q;
    if (cmd_i.ins && !lt) begin
      // first cell not below the new key takes it, later cells shift up
      ent_d   = left_lt_i ? cmd_i.ent : left_ent_i;
      valid_d = left_valid_i;
    end else if (cmd_i.del && at_or_after) begin
      ent_d   = right_ent_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o   = ent_q;
  assign valid_o = valid_q;
  assign lt_o    = lt;
  assign nxt_o   = ent_d;
  assign sel_o   = (MyIdx == cmd_i.position) ? ent_q : '0;

endmodule

### hw/rtl/sorted_priority_queue.sv
// sorted_priority_queue: top level, a chain of spq_cell slots kept in key order.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   in channel  (in_valid_i / in_ready_o / in_data_i): one item per operation.
//     func = insert places (entry_key, entry_tag) before the first stored
//     entry with key >= entry_key; func = delete removes the entry at
//     'position' counted from the head.
//   out channel (out_valid_o / out_ready_i / out_data_o): exactly one result
//     item per accepted input item, in order: status, count after the op,
//     removed entry (zero unless a delete succeeded), head entry and empty.
// Timing:
//   Every cell compares its key with the broadcast key and picks its next
//   value from itself, its left or its right neighbor in the same cycle;
//   the result appears in the output register on the next cycle.
//   Throughput is one item per cycle as long as the receiver keeps
//   taking results.
// Stall: in_ready_o is high when the output register is empty or is being
//   drained this cycle; while a result waits, no new item is taken.
// Reset: all cell valid flags and the count clear; the queue is empty and
//   the stored keys and tags are left as they are.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = DepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int CmpW = (CntW > PosW) ? CntW : PosW;
  localparam logic [CntW-1:0] Full = CntW'(DEPTH);

  logic            in_acc;
  logic            is_full;
  logic            pos_ok;
  logic            ins_ok;
  logic            del_ok;
  cmd_t            cmd;
  logic [CntW-1:0] count_q, count_d;

  entry_t          ent_w   [DEPTH];
  entry_t          sel_w   [DEPTH];
  logic            valid_w [DEPTH];
  logic            lt_w    [DEPTH];
  entry_t          head_nxt;
  entry_t          removed;

  out_item_t       out_q, out_d;
  logic            out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  assign is_full = (count_q == Full);
  assign pos_ok  = (CmpW'(in_data_i.position) < CmpW'(count_q));
  assign ins_ok  = in_acc && (in_data_i.func == FuncInsert) && !is_full;
  assign del_ok  = in_acc && (in_data_i.func == FuncDelete) && pos_ok;

  assign cmd.ins      = ins_ok;
  assign cmd.del      = del_ok;
  assign cmd.ent.key  = in_data_i.entry_key;
  assign cmd.ent.tag  = in_data_i.entry_tag;
  assign cmd.position = in_data_i.position;

  // Cell chain: cell 0 sees an always-valid, always-smaller left side so an
  // insert lands there when nothing is below it; the last cell shifts in
  // an empty slot on delete.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t left_ent;
    logic   left_valid;
    logic   left_lt;
    entry_t right_ent;
    logic   right_valid;

    if (g == 0) begin : g_first
      assign left_ent   = '0;
      assign left_valid = 1'b1;
      assign left_lt    = 1'b1;
    end else begin : g_mid
      assign left_ent   = ent_w[g-1];
      assign left_valid = valid_w[g-1];
      assign left_lt    = lt_w[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_ent   = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_ent   = ent_w[g+1];
      assign right_valid = valid_w[g+1];
    end

    if (g == 0) begin : g_head
      spq_cell #(.INDEX(g)) u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .cmd_i         (cmd),
        .left_ent_i    (left_ent),
        .left_valid_i  (left_valid),
        .left_lt_i     (left_lt),
        .right_ent_i   (right_ent),
        .right_valid_i (right_valid),
        .ent_o         (ent_w[g]),
        .valid_o       (valid_w[g]),
        .lt_o          (lt_w[g]),
        .nxt_o         (head_nxt),
        .sel_o         (sel_w[g])
      );
    end else begin : g_body
      spq_cell #(.INDEX(g)) u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .cmd_i         (cmd),
        .left_ent_i    (left_ent),
        .left_valid_i  (left_valid),
        .left_lt_i     (left_lt),
        .right_ent_i   (right_ent),
        .right_valid_i (right_valid),
        .ent_o         (ent_w[g]),
        .valid_o       (valid_w[g]),
        .lt_o          (lt_w[g]),
        .nxt_o         (),
        .sel_o         (sel_w[g])
      );
    end
  end

  // Only the addressed cell drives a nonzero select word.
  always_comb begin
    removed = '0;
    for (int i = 0; i < DEPTH; i++) begin
      removed = removed | sel_w[i];
    end
  end

  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CntW'(1);
    end else if (del_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    out_d             = '0;
    out_d.entry_count = CountW'(count_d);
    out_d.empty_res   = (count_d == '0);
    if (in_data_i.func == FuncInsert) begin
      out_d.status = is_full ? StatusFull : StatusOk;
    end else begin
      out_d.status = pos_ok ? StatusOk : StatusBadPos;
    end
    if (del_ok) begin
      out_d.removed_key = removed.key;
      out_d.removed_tag = removed.tag;
    end
    if (count_d != '0) begin
      out_d.head_key = head_nxt.key;
      out_d.head_tag = head_nxt.tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  logic [DEPTH-1:0] valid_vec;
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_vec[i] = valid_w[i];
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("entry count above depth");

  a_valid_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("cell valid flags disagree with entry count");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_ok |=> count_q == $past(count_q) + CntW'(1))
    else $error("accepted insert did not grow the queue");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.empty_res == (count_q == '0)))
    else $error("empty flag in result disagrees with entry count");

  a_head_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_w[1] |-> ent_w[0].key <= ent_w[1].key)
    else $error("head entry out of key order");
`endif

endmodule

### test/spq_tb_pkg.sv
// spq_tb_pkg: scoreboard for the sorted priority queue testbench.
// Depends on spq_pkg for the item types and the operation and status codes.
`timescale 1ns / 1ps
package spq_tb_pkg;
  import spq_pkg::*;

  class spq_scoreboard;
    // Shadow of the sorted store, head at index 0
    logic [KeyW-1:0] shadow_key [DepthDef];
    logic [TagW-1:0] shadow_tag [DepthDef];
    int              shadow_count;
    out_item_t       expected_results [$];
    int              mismatches;
    int              results_seen;

    function new();
      foreach (shadow_key[i]) begin
        shadow_key[i] = '0;
        shadow_tag[i] = '0;
      end
      shadow_count = 0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int stored();
      return shadow_count;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function int failures();
      return mismatches;
    endfunction

    // Applies one operation to the shadow store and returns its result item.
    function out_item_t predict_result(in_item_t op);
      out_item_t r;
      int        slot;
      int        i;
      r = '0;
      r.status = StatusOk;
      if (op.func == FuncInsert) begin
        if (shadow_count >= DepthDef) begin
          r.status = StatusFull;
        end else begin
          // new entry goes ahead of the first key >= its own
          slot = 0;
          while (slot < shadow_count && shadow_key[slot] < op.entry_key) slot++;
          for (i = shadow_count; i > slot; i--) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_tag[i] = shadow_tag[i-1];
          end
          shadow_key[slot] = op.entry_key;
          shadow_tag[slot] = op.entry_tag;
          shadow_count++;
        end
      end else begin
        if (op.position >= shadow_count) begin
          r.status = StatusBadPos;
        end else begin
          r.removed_key = shadow_key[op.position];
          r.removed_tag = shadow_tag[op.position];
          for (i = op.position; i + 1 < shadow_count; i++) begin
            shadow_key[i] = shadow_key[i+1];
            shadow_tag[i] = shadow_tag[i+1];
          end
          shadow_count--;
        end
      end
      r.entry_count = shadow_count[CountW-1:0];
      if (shadow_count != 0) begin
        r.head_key = shadow_key[0];
        r.head_tag = shadow_tag[0];
      end
      r.empty_res = (shadow_count == 0);
      return r;
    endfunction

    function void note_accepted(in_item_t op);
      expected_results.push_back(predict_result(op));
    endfunction

    function void compare_field(string name, logic [KeyW-1:0] want, logic [KeyW-1:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d %s: expected %0h, got %0h", results_seen, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: no item expected, got %h", results_seen, got);
      end else begin
        want = expected_results.pop_front();
        compare_field("status", KeyW'(want.status), KeyW'(got.status));
        compare_field("entry_count", KeyW'(want.entry_count), KeyW'(got.entry_count));
        compare_field("removed_key", want.removed_key, got.removed_key);
        compare_field("removed_tag", KeyW'(want.removed_tag), KeyW'(got.removed_tag));
        compare_field("head_key", want.head_key, got.head_key);
        compare_field("head_tag", KeyW'(want.head_tag), KeyW'(got.head_tag));
        compare_field("empty_res", KeyW'(want.empty_res), KeyW'(got.empty_res));
      end
      results_seen++;
    endfunction
  endclass

endpackage

### test/tb_top.sv
// tb_top: random and directed test of sorted_priority_queue against a shadow store.
// Depends on spq_pkg, spq_tb_pkg and the sorted_priority_queue RTL.
`timescale 1ns / 1ps
module tb_top;
  import spq_pkg::*;
  import spq_tb_pkg::*;

  localparam int Depth       = DepthDef;
  localparam int RandomItems = 900;
  // Covers the pass through the block plus margin for the output register
  localparam int DrainCycles = 10;
  // Covers the worst honest gap: the longest idle gap on each side plus the block
  localparam int IdleLimit   = 200;

  // Traffic mix of one random phase
  typedef enum int {
    PhaseFill,
    PhaseDrain,
    PhaseMixed
  } phase_e;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  spq_scoreboard sb = new();

  // When set, that side runs back to back with no idle cycles
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  sorted_priority_queue #(
    .DEPTH(Depth)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 6);
  endfunction

  // Keys lean on the extremes and on a narrow band so equal keys are common.
  function automatic logic [KeyW-1:0] random_key();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return KeyW'($urandom_range(0, 15));
      default: return KeyW'($urandom());
    endcase
  endfunction

  // Unused fields still carry random bits; the block must ignore them.
  function automatic in_item_t ins_op(logic [KeyW-1:0] key, logic [TagW-1:0] tag);
    in_item_t it;
    it.func      = FuncInsert;
    it.entry_key = key;
    it.entry_tag = tag;
    it.position  = PosW'($urandom_range(0, 63));
    return it;
  endfunction

  function automatic in_item_t del_op(logic [PosW-1:0] pos);
    in_item_t it;
    it.func      = FuncDelete;
    it.entry_key = KeyW'($urandom());
    it.entry_tag = TagW'($urandom_range(0, 511));
    it.position  = pos;
    return it;
  endfunction

  // Deletes mostly hit a stored entry; about one in ten goes anywhere in
  // the position range, which also covers delete beyond count.
  function automatic in_item_t random_op(int unsigned ins_pct);
    int n;
    logic [PosW-1:0] pos;
    n = sb.stored();
    if ($urandom_range(0, 99) < ins_pct) begin
      return ins_op(random_key(), TagW'($urandom_range(0, 511)));
    end
    if (n > 0 && $urandom_range(0, 9) != 0) pos = PosW'($urandom_range(0, n - 1));
    else pos = PosW'($urandom_range(0, 63));
    return del_op(pos);
  endfunction

  // Offers one item after a random gap and holds it until the block takes it.
  // Called at a clock edge; returns at the edge of acceptance.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = draw_gap(tx_burst);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_accepted(it);
  endtask

  // Sender goes quiet until every outstanding result has been taken.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Result side: random ready gaps per item, with burst stretches.
  initial begin : result_drain
    int unsigned gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_burst = ~rx_burst;
      gap = draw_gap(rx_burst);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_data_o);
    end
  end

  // Watchdog: ends the run after too many cycles with no item moving.
  initial begin : watchdog
    int idle;
    idle = 0;
    wait (rst_ni === 1'b1);
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("sorted_priority_queue: mismatch");
    $finish;
  end

  initial begin : stimulus
    phase_e      ph;
    int unsigned sent;
    int unsigned span;
    int unsigned pct;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: delete on an empty queue, key and tag extremes, equal keys
    // (newest must land first), delete beyond count, delete of tail and head,
    // then drain back to empty. Insert into a full queue is left to the
    // fill phases below, which run the queue up to capacity.
    send_item(del_op(6'd0));
    send_item(del_op(6'd63));
    send_item(ins_op('1, 9'd511));
    send_item(ins_op('0, 9'd0));
    send_item(ins_op(KeyW'(100), 9'd1));
    send_item(ins_op(KeyW'(100), 9'd2));
    send_item(ins_op(KeyW'(100), 9'd3));
    send_item(del_op(6'd63));
    send_item(del_op(6'd5));
    send_item(del_op(6'd4));
    send_item(del_op(6'd1));
    send_item(del_op(6'd0));
    send_item(ins_op('0, 9'd511));
    send_item(del_op(6'd2));
    send_item(del_op(6'd0));
    send_item(del_op(6'd0));
    send_item(del_op(6'd0));

    // Pressure: let everything drain once before the random part
    hold_until_drained();

    // Random part in phases: fill-heavy phases run the queue full and hit
    // the dropped-insert case, drain-heavy ones empty it again.
    sent = 0;
    while (sent < RandomItems) begin
      ph       = phase_e'($urandom_range(0, 2));
      span     = $urandom_range(20, 60);
      tx_burst = ($urandom_range(0, 3) == 0);
      case (ph)
        PhaseFill:  pct = 90;
        PhaseDrain: pct = 15;
        default:    pct = 50;
      endcase
      repeat (span) begin
        send_item(random_op(pct));
        sent++;
      end
      if ($urandom_range(0, 3) == 0) hold_until_drained();
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    // catch any stray result after the last expected one
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.failures() == 0 && sb.pending() == 0) begin
      $display("sorted_priority_queue: match");
    end else begin
      $display("sorted_priority_queue: mismatch");
    end
    $finish;
  end

endmodule
